>>> design/tbs_pkg.sv
package tbs_pkg;

	// Event kinds carried on cmd; the unused fourth code acts as a service request.
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ARRIVE = 2'd1,
		CMD_SERVE  = 2'd2
	} cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_TOKEN_ADDED   = 3'd0,
		ST_TOKEN_DROPPED = 3'd1,
		ST_QUEUED        = 3'd2,
		ST_TOO_BIG       = 3'd3,
		ST_WAIT_FULL     = 3'd4,
		ST_SERVE         = 3'd5,
		ST_SERVE_EMPTY   = 3'd6
	} status_t;

	// Per-cycle queue operations.
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	localparam logic [15:0] DEPTH_RESET = 16'd10;

endpackage

>>> design/tbs_queue.sv
module tbs_queue #(
	parameter int DW    = 16,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tbs_pkg::queue_ctl_t               ctl,
	input  logic [DW-1:0]                     wdata,
	output logic [DW-1:0]                     head,
	output logic [$clog2(DEPTH+1)-1:0]        fill_next,
	output logic                              empty,
	output logic                              full
);
	import tbs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] head_q, tail_q, head_d, tail_d, rd_addr;
	logic [CW-1:0] fill_q;
	logic [DW-1:0] rd_q, wd_q;
	logic          byp_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	// Pointer and fill updates.
	assign head_d = ctl.pop  ? ptr_next(head_q) : head_q;
	assign tail_d = ctl.push ? ptr_next(tail_q) : tail_q;
	assign rd_addr = head_d;

	always_comb begin
		unique case ({ctl.push, ctl.pop})
			2'b10:   fill_next = fill_q + 1'b1;
			2'b01:   fill_next = fill_q - 1'b1;
			default: fill_next = fill_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_next;
			byp_q  <= ctl.push && (tail_q == rd_addr);
		end
	end

	// Storage with a registered read of the next head; a write to that same
	// entry in this cycle is forwarded through the bypass register.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_q] <= wdata;
		end
		rd_q <= mem_q[rd_addr];
		wd_q <= wdata;
	end

	assign head  = byp_q ? wd_q : rd_q;
	assign empty = (fill_q == '0);
	assign full  = (fill_q == CW'(DEPTH));

endmodule

>>> design/token_bucket_shaper_core.sv
// Token bucket shaper core.
// The event is taken into the input register, then the result register; done is high in the cycle
// after the input register loads.
// Throughput: one event per cycle; busy stays low, so start may be held high.
// The result register is loaded every cycle with an event; the receiver cannot stall.
// Reset (arst_n low) empties both queues, clears the bucket and counters,
// and sets the bucket depth to 10.
module token_bucket_shaper_core #(
	parameter int WAIT_DEPTH  = 16,
	parameter int SERVE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] packet_id,
	input  logic [15:0] tokens_needed,
	output logic        done,
	output logic [2:0]  status,
	output logic        moved,
	output logic [15:0] moved_id,
	output logic [15:0] served_id,
	output logic [15:0] tokens_now,
	output logic [4:0]  wait_count,
	output logic [4:0]  service_count,
	output logic [31:0] dropped_tokens,
	output logic [31:0] dropped_packets,
	output logic [31:0] served_packets
);
	import tbs_pkg::*;

	localparam int WCW = $clog2(WAIT_DEPTH+1);
	localparam int SCW = $clog2(SERVE_DEPTH+1);

	// Input register.
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] pid_s1, need_s1;

	// Architectural state.
	logic [15:0] depth_q, level_q;
	logic [31:0] tdrop_q, pdrop_q, served_q;

	// Queue interfaces.
	queue_ctl_t     wctl, sctl;
	logic [31:0]    whead;
	logic [WCW-1:0] wfill_next;
	logic           wempty, wfull;
	logic [15:0]    shead;
	logic [SCW-1:0] sfill_next;
	logic           sempty, sfull;

	// Event evaluation.
	status_t     st;
	logic        attempt, do_move, do_pop, tinc, pinc;
	logic [15:0] level_a, level_d, hneed, hid;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1  <= cmd;
			pid_s1  <= packet_id;
			need_s1 <= tokens_needed;
		end
	end

	// Decode the event and its effect on the bucket and the queues.
	always_comb begin
		st       = ST_SERVE_EMPTY;
		attempt  = 1'b0;
		do_pop   = 1'b0;
		tinc     = 1'b0;
		pinc     = 1'b0;
		level_a  = level_q;
		wctl     = '0;
		unique case (cmd_s1)
			CMD_TICK: begin
				if (level_q < depth_q) begin
					level_a = level_q + 16'd1;
					st      = ST_TOKEN_ADDED;
				end else begin
					tinc = 1'b1;
					st   = ST_TOKEN_DROPPED;
				end
				attempt = 1'b1;
			end
			CMD_ARRIVE: begin
				if (need_s1 > depth_q) begin
					pinc = 1'b1;
					st   = ST_TOO_BIG;
				end else if (wfull) begin
					pinc = 1'b1;
					st   = ST_WAIT_FULL;
				end else begin
					wctl.push = 1'b1;
					st        = ST_QUEUED;
					attempt   = 1'b1;
				end
			end
			default: begin
				if (!sempty) begin
					do_pop = 1'b1;
					st     = ST_SERVE;
				end
			end
		endcase

		// An arrival into an empty wait queue is its own head.
		hneed   = wempty ? need_s1 : whead[31:16];
		hid     = wempty ? pid_s1 : whead[15:0];
		do_move = attempt && (!wempty || wctl.push) && !sfull && (hneed <= level_a);
		level_d = do_move ? level_a - hneed : level_a;

		wctl.push = wctl.push && valid_s1;
		wctl.pop  = do_move && valid_s1;
		sctl.push = do_move && valid_s1;
		sctl.pop  = do_pop && valid_s1;
	end

	tbs_queue #(
		.DW    (32),
		.DEPTH (WAIT_DEPTH)
	) u_wait_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (wctl),
		.wdata     ({need_s1, pid_s1}),
		.head      (whead),
		.fill_next (wfill_next),
		.empty     (wempty),
		.full      (wfull)
	);

	tbs_queue #(
		.DW    (16),
		.DEPTH (SERVE_DEPTH)
	) u_serve_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.wdata     (hid),
		.head      (shead),
		.fill_next (sfill_next),
		.empty     (sempty),
		.full      (sfull)
	);

	// Bucket, configuration and saturating counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DEPTH_RESET;
			level_q  <= '0;
			tdrop_q  <= '0;
			pdrop_q  <= '0;
			served_q <= '0;
		end else begin
			if (cfg_we) begin
				depth_q <= cfg_wdata;
			end
			if (valid_s1) begin
				level_q <= level_d;
				if (tinc && !(&tdrop_q)) begin
					tdrop_q <= tdrop_q + 32'd1;
				end
				if (pinc && !(&pdrop_q)) begin
					pdrop_q <= pdrop_q + 32'd1;
				end
				if (do_pop && !(&served_q)) begin
					served_q <= served_q + 32'd1;
				end
			end
		end
	end

	// Result register; the counters update at the same edge, so they are read
	// straight from the state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status        <= st;
			moved         <= do_move;
			moved_id      <= do_move ? hid : 16'd0;
			served_id     <= do_pop ? shead : 16'd0;
			tokens_now    <= level_d;
			wait_count    <= 5'(wfill_next);
			service_count <= 5'(sfill_next);
		end
	end

	assign dropped_tokens  = tdrop_q;
	assign dropped_packets = pdrop_q;
	assign served_packets  = served_q;

endmodule

>>> design/tbs_checker.sv
module tbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic        moved,
	input logic [15:0] moved_id,
	input logic [15:0] served_id,
	input logic [4:0]  service_count
);
	import tbs_pkg::*;

	// Every accepted transfer yields its result strobe after the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing two cycles after start");

	// No moved id is reported without a move.
	a_moved_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && !moved |-> moved_id == 16'd0)
		else $error("moved_id set without a move");

	// Only a successful service reports a served id.
	a_served_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_SERVE) |-> served_id == 16'd0)
		else $error("served_id set without a service");

	// A service on an empty queue leaves it empty.
	a_serve_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_SERVE_EMPTY) |-> service_count == 5'd0)
		else $error("service queue not empty after empty service");

endmodule

bind token_bucket_shaper_core tbs_checker u_tbs_checker (.*);

>>> tb/sv/tb_token_bucket_shaper_core.sv
`timescale 1ns / 100ps

module tb_token_bucket_shaper_core;
	import tbs_pkg::*;

	localparam int WAIT_SLOTS = 16;
	localparam int SERVE_SLOTS = 16;
	localparam int STALL_LIMIT = 1000;
	localparam int PRINT_LIMIT = 100;
	// The fourth command code has no enum member; the block treats it as a service request.
	localparam logic [1:0] CMD_SERVE_ALT = 2'd3;

	typedef struct packed {
		status_t     status;
		logic        moved;
		logic [15:0] moved_id;
		logic [15:0] served_id;
		logic [15:0] tokens_now;
		logic [4:0]  wait_count;
		logic [4:0]  service_count;
		logic [31:0] dropped_tokens;
		logic [31:0] dropped_packets;
		logic [31:0] served_packets;
	} shaper_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [15:0] packet_id;
	logic [15:0] tokens_needed;
	logic        done;
	logic [2:0]  status;
	logic        moved;
	logic [15:0] moved_id;
	logic [15:0] served_id;
	logic [15:0] tokens_now;
	logic [4:0]  wait_count;
	logic [4:0]  service_count;
	logic [31:0] dropped_tokens;
	logic [31:0] dropped_packets;
	logic [31:0] served_packets;

	// Shadow copy of the shaper state.
	logic [15:0] depth_setting = DEPTH_RESET;
	logic [15:0] bucket_fill = '0;
	logic [15:0] wait_id_mem [WAIT_SLOTS];
	logic [15:0] wait_need_mem [WAIT_SLOTS];
	int          wait_rd = 0;
	int          wait_wr = 0;
	int          wait_fill = 0;
	logic [15:0] serve_id_mem [SERVE_SLOTS];
	int          serve_rd = 0;
	int          serve_wr = 0;
	int          serve_fill = 0;
	logic [31:0] token_drops = '0;
	logic [31:0] packet_drops = '0;
	logic [31:0] serve_total = '0;

	shaper_result_t pending_results [$];
	shaper_result_t oldest;
	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          sender_gaps = 1'b1;

	token_bucket_shaper_core #(
		.WAIT_DEPTH(WAIT_SLOTS),
		.SERVE_DEPTH(SERVE_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.packet_id(packet_id),
		.tokens_needed(tokens_needed),
		.done(done),
		.status(status),
		.moved(moved),
		.moved_id(moved_id),
		.served_id(served_id),
		.tokens_now(tokens_now),
		.wait_count(wait_count),
		.service_count(service_count),
		.dropped_tokens(dropped_tokens),
		.dropped_packets(dropped_packets),
		.served_packets(served_packets)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one event to the shadow state and returns the result it should produce.
	function automatic shaper_result_t next_shaper_result(input logic [1:0] ev,
			input logic [15:0] pid, input logic [15:0] need);
		shaper_result_t r;
		logic attempt;
		r = '0;
		attempt = 1'b0;
		case (ev)
		CMD_TICK: begin
			if (bucket_fill < depth_setting) begin
				bucket_fill = bucket_fill + 16'd1;
				r.status = ST_TOKEN_ADDED;
			end else begin
				if (token_drops != '1)
					token_drops = token_drops + 32'd1;
				r.status = ST_TOKEN_DROPPED;
			end
			attempt = 1'b1;
		end
		CMD_ARRIVE: begin
			if (need > depth_setting) begin
				if (packet_drops != '1)
					packet_drops = packet_drops + 32'd1;
				r.status = ST_TOO_BIG;
			end else if (wait_fill >= WAIT_SLOTS) begin
				if (packet_drops != '1)
					packet_drops = packet_drops + 32'd1;
				r.status = ST_WAIT_FULL;
			end else begin
				wait_id_mem[wait_wr] = pid;
				wait_need_mem[wait_wr] = need;
				wait_wr = (wait_wr + 1) % WAIT_SLOTS;
				wait_fill++;
				r.status = ST_QUEUED;
				attempt = 1'b1;
			end
		end
		default: begin
			if (serve_fill == 0) begin
				r.status = ST_SERVE_EMPTY;
			end else begin
				r.served_id = serve_id_mem[serve_rd];
				serve_rd = (serve_rd + 1) % SERVE_SLOTS;
				serve_fill--;
				if (serve_total != '1)
					serve_total = serve_total + 32'd1;
				r.status = ST_SERVE;
			end
		end
		endcase

		// The wait-queue head moves at most once, and only when its tokens are there.
		if (attempt && wait_fill != 0 && serve_fill < SERVE_SLOTS &&
				wait_need_mem[wait_rd] <= bucket_fill) begin
			bucket_fill = bucket_fill - wait_need_mem[wait_rd];
			r.moved = 1'b1;
			r.moved_id = wait_id_mem[wait_rd];
			serve_id_mem[serve_wr] = wait_id_mem[wait_rd];
			serve_wr = (serve_wr + 1) % SERVE_SLOTS;
			serve_fill++;
			wait_rd = (wait_rd + 1) % WAIT_SLOTS;
			wait_fill--;
		end

		r.tokens_now = bucket_fill;
		r.wait_count = 5'(wait_fill);
		r.service_count = 5'(serve_fill);
		r.dropped_tokens = token_drops;
		r.dropped_packets = packet_drops;
		r.served_packets = serve_total;
		return r;
	endfunction

	// Printing stops after the first hundred mismatches to keep the log readable.
	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Check each result transfer against the oldest prediction, then predict new transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none actual status %0d", $time, status);
				end else begin
					oldest = pending_results.pop_front();
					compare_field("status", 32'(oldest.status), 32'(status));
					compare_field("moved", 32'(oldest.moved), 32'(moved));
					compare_field("moved_id", 32'(oldest.moved_id), 32'(moved_id));
					compare_field("served_id", 32'(oldest.served_id), 32'(served_id));
					compare_field("tokens_now", 32'(oldest.tokens_now), 32'(tokens_now));
					compare_field("wait_count", 32'(oldest.wait_count), 32'(wait_count));
					compare_field("service_count", 32'(oldest.service_count),
						32'(service_count));
					compare_field("dropped_tokens", oldest.dropped_tokens, dropped_tokens);
					compare_field("dropped_packets", oldest.dropped_packets, dropped_packets);
					compare_field("served_packets", oldest.served_packets, served_packets);
				end
			end
			if (cfg_we)
				depth_setting = cfg_wdata;
			if (start && !busy)
				pending_results.push_back(next_shaper_result(cmd, packet_id, tokens_needed));
		end
	end

	// Watchdog: the run ends if neither side transfers anything for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Sends one event, with an occasional idle burst ahead of it.
	task automatic send_event(input logic [1:0] ev, input logic [15:0] pid,
			input logic [15:0] need);
		int gap;
		gap = 0;
		if (sender_gaps && $urandom_range(3) == 0)
			gap = $urandom_range(4, 1);
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= ev;
		packet_id <= pid;
		tokens_needed <= need;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Random event drawn from a command mix; queued needs stay at or below max_need.
	task automatic send_random_event(input int pct_tick, input int pct_arrive,
			input int max_need);
		int roll;
		int hi;
		logic [1:0] ev;
		logic [15:0] need;
		hi = (max_need < int'(depth_setting)) ? max_need : int'(depth_setting);
		roll = $urandom_range(99);
		if (roll < pct_tick)
			ev = CMD_TICK;
		else if (roll < pct_tick + pct_arrive)
			ev = CMD_ARRIVE;
		else
			ev = ($urandom_range(7) == 0) ? CMD_SERVE_ALT : CMD_SERVE;
		case ($urandom_range(9))
		0: begin
			need = 16'($urandom_range(16'hFFFF));
			if (need <= depth_setting)
				need = 16'(int'(need) % (hi + 1));
		end
		1: need = depth_setting + 16'd1;
		2: need = '0;
		default: need = 16'($urandom_range(hi));
		endcase
		send_event(ev, 16'($urandom_range(16'hFFFF)), need);
	endtask

	task automatic send_random_batch(input int count, input int pct_tick,
			input int pct_arrive, input int max_need);
		repeat (count) send_random_event(pct_tick, pct_arrive, max_need);
	endtask

	// Holds off the sender until every predicted result has arrived.
	task automatic wait_drained;
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_bucket_depth(input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Empty service queue, the fourth command code, extreme ids and needs at reset depth.
	task automatic test_serve_and_arrivals;
		send_event(CMD_SERVE, 16'h0000, 16'h0000);
		send_event(CMD_SERVE_ALT, 16'hFFFF, 16'hFFFF);
		send_event(CMD_ARRIVE, 16'hFFFF, 16'h0000);
		send_event(CMD_ARRIVE, 16'h0000, 16'hFFFF);
		send_event(CMD_ARRIVE, 16'h1234, DEPTH_RESET + 16'd1);
		send_event(CMD_ARRIVE, 16'h00A5, 16'd3);
		repeat (3) send_event(CMD_TICK, 16'hFFFF, 16'hFFFF);
		send_event(CMD_SERVE, 16'h0000, 16'h0000);
		send_event(CMD_SERVE_ALT, 16'h0000, 16'h0000);
	endtask

	// Depth zero drops every token; the largest depth lets a waiting packet collect tokens.
	task automatic test_depth_extremes;
		set_bucket_depth(16'h0000);
		send_event(CMD_TICK, 16'h0000, 16'h0000);
		send_event(CMD_ARRIVE, 16'h5A5A, 16'd1);
		send_event(CMD_ARRIVE, 16'h7777, 16'd0);
		send_event(CMD_SERVE, 16'h0000, 16'h0000);
		set_bucket_depth(16'hFFFF);
		send_event(CMD_ARRIVE, 16'h4242, 16'd2);
		repeat (2) send_event(CMD_TICK, 16'h0000, 16'h0000);
	endtask

	// Lowering the depth below the level keeps the level and makes ticks drop.
	task automatic test_depth_lowered;
		repeat (3) send_event(CMD_TICK, 16'h0000, 16'h0000);
		set_bucket_depth(16'd2);
		send_event(CMD_TICK, 16'h0000, 16'h0000);
		send_event(CMD_ARRIVE, 16'hC3C3, 16'd3);
		send_event(CMD_ARRIVE, 16'h3C3C, 16'd2);
		send_event(CMD_TICK, 16'h0000, 16'h0000);
		send_event(CMD_TICK, 16'h0000, 16'h0000);
	endtask

	// Mixed traffic over a range of depths.
	task automatic test_random_traffic;
		set_bucket_depth(16'd10);
		send_random_batch(130, 40, 35, 10);
		set_bucket_depth(16'd1);
		send_random_batch(130, 40, 35, 1);
		set_bucket_depth(16'd4);
		send_random_batch(130, 45, 35, 4);
		set_bucket_depth(16'hFFFF);
		send_random_batch(130, 40, 35, 8);
		set_bucket_depth(16'd40);
		send_random_batch(130, 45, 35, 40);
		set_bucket_depth(16'($urandom_range(30, 2)));
		send_random_batch(130, 40, 35, 30);
	endtask

	// Arrivals outrun the tokens until the wait queue overflows, then it recovers.
	task automatic test_wait_queue_full;
		set_bucket_depth(16'd30);
		send_random_batch(150, 8, 82, 30);
		send_random_batch(250, 70, 10, 5);
	endtask

	// Zero-token packets with few service requests fill the service queue.
	task automatic test_service_queue_full;
		set_bucket_depth(16'd10);
		send_random_batch(120, 20, 75, 0);
		send_random_batch(150, 20, 10, 3);
	endtask

	task automatic test_pause_until_drained;
		send_random_batch(40, 40, 35, 10);
		wait_drained();
		send_random_batch(40, 40, 35, 10);
	endtask

	// Back-to-back transfers with start held high.
	task automatic test_back_to_back;
		sender_gaps = 1'b0;
		send_random_batch(250, 40, 35, 10);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		cmd = CMD_TICK;
		packet_id = '0;
		tokens_needed = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_serve_and_arrivals();
		test_depth_extremes();
		test_depth_lowered();
		test_random_traffic();
		test_wait_queue_full();
		test_service_queue_full();
		test_pause_until_drained();
		test_back_to_back();

		wait_drained();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
design/tbs_pkg.sv
design/tbs_queue.sv
design/token_bucket_shaper_core.sv
design/tbs_checker.sv
tb/sv/tb_token_bucket_shaper_core.sv
